FILE: design/dhkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkm_pkg: shared definitions for the Diffie-Hellman modexp core
// Field widths, register indexes and reset values, sequencer states.
// ----------------------------------------------------------------------------
package dhkm_pkg;

	// Payload and register field widths
	localparam int FIELD_W      = 32;
	localparam int KEY_BITS_DEF = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODULUS   = 1'd0;
	localparam cfg_idx_t REG_GENERATOR = 1'd1;

	// Register reset values
	localparam logic [FIELD_W-1:0] MODULUS_RESET   = 32'd23;
	localparam logic [FIELD_W-1:0] GENERATOR_RESET = 32'd5;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_WRITE
	} dhkm_state_t;

endpackage

FILE: design/diffie_hellman_key_modexp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffie_hellman_key_modexp_core: key = base ^ private_key mod modulus
// Square-and-multiply over one shared shift-add modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid / in_stall): mode, private_key, peer_key. Mode 0 uses
//   the generator register as base (public key), mode 1 uses peer_key (shared
//   key). in_stall is high while a beat is being worked on.
//   Output beat (out_valid / out_stall): key_value and bad_setup, which flags a
//   generator below 2 or not below the modulus.
//   Config: cfg_we writes cfg_data into the register at cfg_index (0 modulus,
//   1 generator); write only while the core is idle.
// Sequence:
//   One modular multiply takes one multiplier bit per cycle in the shared
//   multiplier. The base is reduced first, then each exponent bit takes a
//   square plus a multiply when the bit is set, then the result is loaded
//   into the output register. A modulus below 2 skips straight to the output.
//   The core goes back to idle before the next beat is taken, so a new beat
//   is accepted only after the last result has entered the output register.
// Reset: registers return to modulus 23, generator 5; no beat pending.
// Stall: the result waits in the output register; while it is still held
//   the next beat is accepted and computed, and its result waits in the core.
module diffie_hellman_key_modexp_core
	import dhkm_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// config write port
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [FIELD_W-1:0] cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [FIELD_W-1:0] private_key,
	input  logic [FIELD_W-1:0] peer_key,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] key_value,
	output logic               bad_setup
);

	localparam int W  = KEY_BITS;
	localparam int CW = $clog2(KEY_BITS);
	localparam logic [CW-1:0] LAST_STEP = CW'(KEY_BITS - 1);

	// Configuration registers
	logic [FIELD_W-1:0] modulus_q, generator_q;

	// Sequencer and datapath state
	dhkm_state_t state_q, state_d;
	logic [W-1:0]  m_q;      // working modulus
	logic [W-1:0]  e_q;      // exponent, shifted left per bit
	logic [W-1:0]  base_q;   // reduced base
	logic [W-1:0]  mx_q;     // multiplicand
	logic [W-1:0]  my_q;     // multiplier, scanned from its top bit
	logic [W-1:0]  pa_q;     // partial product
	logic [W-1:0]  res_q;    // finished key
	logic          bad_q;
	logic [CW-1:0] cnt_q;    // multiplier step
	logic [CW-1:0] ebit_q;   // exponent bits done

	// Output register
	logic               out_valid_q;
	logic [FIELD_W-1:0] key_q;
	logic               bad_out_q;

	// Input beat view, masked to the key width
	logic [W-1:0] m_in, g_in, e_in, base_in;
	logic         in_accept, out_free, step_last, ebit_last, busy;

	// Shared modular multiply step: pa = (2*pa + bit*mx) mod m
	logic [W+1:0] v, d1, d2;
	logic [W-1:0] pa_next;

	assign m_in    = W'(modulus_q);
	assign g_in    = W'(generator_q);
	assign e_in    = W'(private_key);
	assign base_in = mode ? W'(peer_key) : g_in;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_last = (cnt_q == LAST_STEP);
	assign ebit_last = (ebit_q == LAST_STEP);
	assign busy      = (state_q == ST_REDUCE) || (state_q == ST_SQUARE) ||
	                   (state_q == ST_MULT);

	always_comb begin
		v  = {1'b0, pa_q, 1'b0} + (my_q[W-1] ? {2'b00, mx_q} : '0);
		d1 = v - {2'b00, m_q};
		d2 = v - {1'b0, m_q, 1'b0};
		if (!d2[W+1]) begin
			pa_next = d2[W-1:0];
		end else if (!d1[W+1]) begin
			pa_next = d1[W-1:0];
		end else begin
			pa_next = v[W-1:0];
		end
	end

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MODULUS_RESET;
			generator_q <= GENERATOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:   modulus_q   <= cfg_data;
				REG_GENERATOR: generator_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (m_in < W'(2)) ? ST_WRITE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (step_last) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (step_last) begin
					if (e_q[W-1]) begin
						state_d = ST_MULT;
					end else if (ebit_last) begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_MULT: begin
				if (step_last) begin
					state_d = ebit_last ? ST_WRITE : ST_SQUARE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ebit_q <= '0;
		end else if (in_accept) begin
			cnt_q  <= '0;
			ebit_q <= '0;
		end else if (busy) begin
			cnt_q <= step_last ? '0 : cnt_q + 1'b1;
			if (step_last && (state_q == ST_MULT ||
			                  (state_q == ST_SQUARE && !e_q[W-1]))) begin
				ebit_q <= ebit_q + 1'b1;
			end
		end
	end

	// Datapath: operand load, multiply steps, result hand-off
	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_q   <= m_in;
			e_q   <= e_in;
			bad_q <= (g_in < W'(2)) || (g_in >= m_in);
			mx_q  <= W'(1);
			my_q  <= base_in;
			pa_q  <= '0;
			res_q <= '0;
		end else if (busy) begin
			if (!step_last) begin
				pa_q <= pa_next;
				my_q <= my_q << 1;
			end else begin
				pa_q <= '0;
				case (state_q)
					ST_REDUCE: begin
						// accumulator starts at 1; first square is 1 * 1
						base_q <= pa_next;
						mx_q   <= W'(1);
						my_q   <= W'(1);
					end
					ST_SQUARE: begin
						mx_q <= pa_next;
						if (e_q[W-1]) begin
							my_q <= base_q;
						end else begin
							my_q  <= pa_next;
							e_q   <= e_q << 1;
							res_q <= pa_next;
						end
					end
					default: begin
						mx_q  <= pa_next;
						my_q  <= pa_next;
						e_q   <= e_q << 1;
						res_q <= pa_next;
					end
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && out_free) begin
			key_q     <= FIELD_W'(res_q);
			bad_out_q <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign key_value = key_q;
	assign bad_setup = bad_out_q;

endmodule
